@@ src/pfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants for the 2D particle repulsion step engine.
// ----------------------------------------------------------------------------
package pfs_pkg;

	// signed Q3.12 value
	typedef logic signed [15:0] q12_t;

	// operation selector carried on s_tuser
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_STEP = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// register indexes, byte address = 4 * index
	localparam logic [2:0] CFG_RADIUS    = 3'd0;
	localparam logic [2:0] CFG_GAIN      = 3'd1;
	localparam logic [2:0] CFG_BOUNDARY  = 3'd2;
	localparam logic [2:0] CFG_GRAV_EN   = 3'd3;
	localparam logic [2:0] CFG_GRAV_INC  = 3'd4;
	localparam logic [2:0] CFG_TIME_STEP = 3'd5;
	localparam logic [2:0] CFG_DENSITY   = 3'd6;

	// register reset values
	localparam logic [14:0] RST_RADIUS    = 15'd410;
	localparam logic [15:0] RST_GAIN      = 16'd4096;
	localparam logic [14:0] RST_BOUNDARY  = 15'd4096;
	localparam logic [15:0] RST_GRAV_INC  = 16'hFEBF;
	localparam logic [14:0] RST_TIME_STEP = 15'd33;
	localparam logic [14:0] RST_DENSITY   = 15'd410;

	// magnitude of the wall reflection factor 0.8 in Q3.12
	localparam logic [15:0] REFLECT_MAG = 16'd3277;
	// half an lsb for rounding a Q.24 product back to Q.12
	localparam int unsigned ROUND_HALF = 2048;
	// quotient bits of the force divide
	localparam int unsigned DIV_BITS = 37;

endpackage

@@ src/particle_fluid_step.sv @@
// ----------------------------------------------------------------------------
// particle_fluid_step
// All-pairs 2D particle repulsion step engine, Q3.12 fixed point.
// ----------------------------------------------------------------------------
// One input beat on s_* carries the mode on s_tuser and a particle on s_tdata.
// Every input beat gives exactly one output beat on m_*; it is all zero except
// for a read of a valid index, which returns the particle and its neighbour count.
// Configuration goes through the APB port; the user must write it only while
// the block is idle, and the block itself does not enforce this.
// All work runs through one 30x16 multiplier, one restoring divider (one
// quotient bit per cycle) and a bit-pair square root unit under a sequencer;
// s_tready is low while an item is in work and while the output beat waits.
// A load, an unused mode or a read of an invalid index gives its output beat
// in the cycle after it is taken. A read walks every other particle to count
// its neighbours. A step walks every ordered pair of particles, runs a square
// root and two divides for each pair within the interaction radius, then
// integrates every particle.
// After reset the particle memories are cleared, one entry a cycle, and no
// item is taken until every entry is clear. A stalled m_tready holds the beat
// in the output register and the block takes no new item until it is taken.
module particle_fluid_step
	import pfs_pkg::*;
#(
	parameter int NUM_PARTICLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	// particle_index[5:0], load_pos_x[21:6], load_pos_y[37:22],
	// load_vel_x[53:38], load_vel_y[69:54], zero[71:70]
	input  logic [71:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	// output beats
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_pos_x[15:0], out_pos_y[31:16], out_vel_x[47:32], out_vel_y[63:48],
	// neighbour_count[69:64], zero[71:70]
	output logic [71:0] m_tdata
);

	localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
	localparam int CW = $clog2(NUM_PARTICLES + 1);
	localparam logic [CW-1:0] LAST_IDX = CW'(NUM_PARTICLES - 1);
	localparam logic [CW-1:0] END_IDX  = CW'(NUM_PARTICLES);

	// sequencer states
	localparam logic [4:0] ST_CLR     = 5'd0;
	localparam logic [4:0] ST_IDLE    = 5'd1;
	localparam logic [4:0] ST_OUT     = 5'd2;
	localparam logic [4:0] ST_I_RD    = 5'd3;
	localparam logic [4:0] ST_I_LAT   = 5'd4;
	localparam logic [4:0] ST_RSQ     = 5'd5;
	localparam logic [4:0] ST_RSQ2    = 5'd6;
	localparam logic [4:0] ST_J_RD    = 5'd7;
	localparam logic [4:0] ST_J_DX    = 5'd8;
	localparam logic [4:0] ST_SQX     = 5'd9;
	localparam logic [4:0] ST_SQY     = 5'd10;
	localparam logic [4:0] ST_D2      = 5'd11;
	localparam logic [4:0] ST_CHK     = 5'd12;
	localparam logic [4:0] ST_F       = 5'd13;
	localparam logic [4:0] ST_SQRT    = 5'd14;
	localparam logic [4:0] ST_MUL_LO  = 5'd15;
	localparam logic [4:0] ST_MUL_HI  = 5'd16;
	localparam logic [4:0] ST_SUM     = 5'd17;
	localparam logic [4:0] ST_DIV     = 5'd18;
	localparam logic [4:0] ST_ACC     = 5'd19;
	localparam logic [4:0] ST_J_NEXT  = 5'd20;
	localparam logic [4:0] ST_I_WB    = 5'd21;
	localparam logic [4:0] ST_G_RD    = 5'd22;
	localparam logic [4:0] ST_G_LAT   = 5'd23;
	localparam logic [4:0] ST_G_MX    = 5'd24;
	localparam logic [4:0] ST_G_MY    = 5'd25;
	localparam logic [4:0] ST_G_PY    = 5'd26;
	localparam logic [4:0] ST_G_RX    = 5'd27;
	localparam logic [4:0] ST_G_RY    = 5'd28;

	// saturate a wide signed sum to 16 bits
	function automatic q12_t sat16(input logic signed [40:0] v);
		if (v > 41'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -41'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// magnitude of a signed 16 bit value
	function automatic logic [15:0] mag16(input q12_t v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	// configuration registers
	logic [14:0] cfg_radius_q;
	q12_t        cfg_gain_q;
	logic [14:0] cfg_bound_q;
	logic        cfg_grav_en_q;
	q12_t        cfg_grav_q;
	logic [14:0] cfg_dt_q;
	logic [14:0] cfg_dens_q;

	// control
	logic [4:0]    state_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic          cnt_mode_q;
	logic          axis_q;
	logic [5:0]    dcnt_q;

	// datapath
	q12_t               xi_q, yi_q, vxi_q, vyi_q;
	q12_t               rd_px_q, rd_py_q, rd_vx_q, rd_vy_q;
	logic signed [16:0] dx_q, dy_q;
	logic [29:0]        r2_q;
	logic [33:0]        d2_q;
	logic [45:0]        f_q;
	logic [45:0]        prod_q;
	logic [29:0]        sq_v_q, sq_res_q, sq_bit_q;
	logic [38:0]        a_lo_q;
	logic [36:0]        dnum_q;
	logic [14:0]        rem_q;
	logic signed [39:0] acc_x_q, acc_y_q;
	logic [5:0]         count_q;
	q12_t               nx_q, ny_q, nvx_q;
	logic               clx_q, cly_q;
	logic [71:0]        m_tdata_q;

	// particle memories
	q12_t mem_px [NUM_PARTICLES];
	q12_t mem_py [NUM_PARTICLES];
	q12_t mem_vx [NUM_PARTICLES];
	q12_t mem_vy [NUM_PARTICLES];

	logic          s_beat;
	logic [1:0]    in_mode;
	logic [5:0]    in_idx;
	logic          idx_ok;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          we_pos, we_vel;
	q12_t          wr_px, wr_py, wr_vx, wr_vy;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_radius_q  <= RST_RADIUS;
			cfg_gain_q    <= RST_GAIN;
			cfg_bound_q   <= RST_BOUNDARY;
			cfg_grav_en_q <= 1'b0;
			cfg_grav_q    <= RST_GRAV_INC;
			cfg_dt_q      <= RST_TIME_STEP;
			cfg_dens_q    <= RST_DENSITY;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				CFG_RADIUS:    cfg_radius_q  <= pwdata[14:0];
				CFG_GAIN:      cfg_gain_q    <= pwdata[15:0];
				CFG_BOUNDARY:  cfg_bound_q   <= pwdata[14:0];
				CFG_GRAV_EN:   cfg_grav_en_q <= pwdata[0];
				CFG_GRAV_INC:  cfg_grav_q    <= pwdata[15:0];
				CFG_TIME_STEP: cfg_dt_q      <= pwdata[14:0];
				CFG_DENSITY:   cfg_dens_q    <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[4:2])
			CFG_RADIUS:    prdata = {17'd0, cfg_radius_q};
			CFG_GAIN:      prdata = {16'd0, cfg_gain_q};
			CFG_BOUNDARY:  prdata = {17'd0, cfg_bound_q};
			CFG_GRAV_EN:   prdata = {31'd0, cfg_grav_en_q};
			CFG_GRAV_INC:  prdata = {16'd0, cfg_grav_q};
			CFG_TIME_STEP: prdata = {17'd0, cfg_dt_q};
			CFG_DENSITY:   prdata = {17'd0, cfg_dens_q};
			default:       prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// stream side
	// ------------------------------------------------------------------
	assign s_tready = (state_q == ST_IDLE);
	assign s_beat   = s_tvalid && s_tready;
	assign in_mode  = s_tuser;
	assign in_idx   = s_tdata[5:0];
	assign idx_ok   = ({26'd0, in_idx} < 32'(NUM_PARTICLES));
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// shared multiplier operand select
	// ------------------------------------------------------------------
	logic signed [16:0] d_axis;
	logic [15:0]        d_mag;
	logic [14:0]        rad;
	logic [29:0]        mul_a;
	logic [15:0]        mul_b;

	assign d_axis = axis_q ? dy_q : dx_q;
	assign d_mag  = d_axis[16] ? 16'(-d_axis) : 16'(d_axis);
	assign rad    = cnt_mode_q ? cfg_dens_q : cfg_radius_q;

	always_comb begin
		mul_a = 30'd0;
		mul_b = 16'd0;
		unique case (state_q)
			ST_RSQ: begin
				mul_a = 30'(rad);
				mul_b = 16'(rad);
			end
			ST_SQX: begin
				mul_a = 30'(dx_q[16] ? 16'(-dx_q) : 16'(dx_q));
				mul_b = dx_q[16] ? 16'(-dx_q) : 16'(dx_q);
			end
			ST_SQY: begin
				mul_a = 30'(dy_q[16] ? 16'(-dy_q) : 16'(dy_q));
				mul_b = dy_q[16] ? 16'(-dy_q) : 16'(dy_q);
			end
			ST_CHK: begin
				mul_a = r2_q - d2_q[29:0];
				mul_b = mag16(cfg_gain_q);
			end
			ST_MUL_LO: begin
				mul_a = 30'(f_q[22:0]);
				mul_b = d_mag;
			end
			ST_MUL_HI: begin
				mul_a = 30'(f_q[45:23]);
				mul_b = d_mag;
			end
			ST_G_MX: begin
				mul_a = 30'(mag16(vxi_q));
				mul_b = 16'(cfg_dt_q);
			end
			ST_G_MY: begin
				mul_a = 30'(mag16(vyi_q));
				mul_b = 16'(cfg_dt_q);
			end
			ST_G_PY: begin
				mul_a = 30'(mag16(vxi_q));
				mul_b = REFLECT_MAG;
			end
			ST_G_RX: begin
				mul_a = 30'(mag16(vyi_q));
				mul_b = REFLECT_MAG;
			end
			default: ;
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		prod_q <= 46'(mul_a) * 46'(mul_b);
	end

	// ------------------------------------------------------------------
	// square root step, divide step
	// ------------------------------------------------------------------
	logic [29:0] sq_try;
	logic        sq_take;
	logic [15:0] rem_sh;
	logic [14:0] sq_root;
	logic        div_take;
	logic [61:0] a_sum;

	assign sq_try   = sq_res_q + sq_bit_q;
	assign sq_take  = (sq_v_q >= sq_try);
	assign sq_root  = sq_res_q[14:0];
	assign rem_sh   = {rem_q, dnum_q[36]};
	assign div_take = (rem_sh >= {1'b0, sq_root});
	assign a_sum    = 62'(a_lo_q) + (62'(prod_q[38:0]) << 23);

	// ------------------------------------------------------------------
	// integration: position update with clamp, wall reflection
	// ------------------------------------------------------------------
	q12_t               ip_pos, ip_vel;
	logic [31:0]        ip_rsum;
	logic [19:0]        ip_rmag;
	logic signed [19:0] ip_sum, ip_bound;
	logic               ip_lo, ip_hi;
	q12_t               ip_new;
	logic [27:0]        rf_sum;
	q12_t               rf_vel;
	q12_t               rf_src;

	assign ip_pos   = (state_q == ST_G_MY) ? xi_q : yi_q;
	assign ip_vel   = (state_q == ST_G_MY) ? vxi_q : vyi_q;
	assign ip_rsum  = {1'b0, prod_q[30:0]} + 32'(ROUND_HALF);
	assign ip_rmag  = {1'b0, ip_rsum[30:12]};
	assign ip_bound = {5'd0, cfg_bound_q};
	assign ip_sum   = 20'(ip_pos) + (ip_vel[15] ? -$signed(ip_rmag) : $signed(ip_rmag));
	assign ip_lo    = (ip_sum < -ip_bound);
	assign ip_hi    = (ip_sum > ip_bound);
	assign ip_new   = ip_lo ? 16'(-ip_bound) : (ip_hi ? 16'(ip_bound) : ip_sum[15:0]);

	assign rf_src = (state_q == ST_G_RX) ? vxi_q : vyi_q;
	assign rf_sum = {1'b0, prod_q[26:0]} + 28'(ROUND_HALF);
	assign rf_vel = rf_src[15] ? 16'(rf_sum[27:12]) : 16'(-$signed(16'(rf_sum[27:12])));

	// ------------------------------------------------------------------
	// velocity write back with summed pair forces
	// ------------------------------------------------------------------
	q12_t wb_vx, wb_vy, grav_vy;

	assign wb_vx   = sat16(41'(vxi_q) + 41'(acc_x_q));
	assign wb_vy   = sat16(41'(vyi_q) + 41'(acc_y_q));
	assign grav_vy = sat16(41'(rd_vy_q) + 41'(cfg_grav_q));

	// ------------------------------------------------------------------
	// memory ports
	// ------------------------------------------------------------------
	assign rd_addr = (state_q == ST_J_RD) ? j_q[AW-1:0] : i_q[AW-1:0];

	always_comb begin
		we_pos  = 1'b0;
		we_vel  = 1'b0;
		wr_addr = i_q[AW-1:0];
		wr_px   = '0;
		wr_py   = '0;
		wr_vx   = '0;
		wr_vy   = '0;
		unique case (state_q)
			ST_CLR: begin
				we_pos = 1'b1;
				we_vel = 1'b1;
			end
			ST_IDLE: begin
				if (s_beat && in_mode == MODE_LOAD && idx_ok) begin
					we_pos  = 1'b1;
					we_vel  = 1'b1;
					wr_addr = AW'(in_idx);
					wr_px   = s_tdata[21:6];
					wr_py   = s_tdata[37:22];
					wr_vx   = s_tdata[53:38];
					wr_vy   = s_tdata[69:54];
				end
			end
			ST_I_WB: begin
				we_vel = 1'b1;
				wr_vx  = wb_vx;
				wr_vy  = wb_vy;
			end
			ST_G_RY: begin
				we_pos = 1'b1;
				we_vel = 1'b1;
				wr_px  = nx_q;
				wr_py  = ny_q;
				wr_vx  = nvx_q;
				wr_vy  = cly_q ? rf_vel : vyi_q;
			end
			default: ;
		endcase
	end

	// position memories
	always_ff @(posedge clk) begin
		if (we_pos) begin
			mem_px[wr_addr] <= wr_px;
			mem_py[wr_addr] <= wr_py;
		end
		rd_px_q <= mem_px[rd_addr];
		rd_py_q <= mem_py[rd_addr];
	end

	// velocity memories
	always_ff @(posedge clk) begin
		if (we_vel) begin
			mem_vx[wr_addr] <= wr_vx;
			mem_vy[wr_addr] <= wr_vy;
		end
		rd_vx_q <= mem_vx[rd_addr];
		rd_vy_q <= mem_vy[rd_addr];
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			i_q        <= '0;
			j_q        <= '0;
			cnt_mode_q <= 1'b0;
			axis_q     <= 1'b0;
			dcnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					if (i_q == LAST_IDX) begin
						i_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_beat) begin
						if (in_mode == MODE_STEP) begin
							i_q        <= '0;
							cnt_mode_q <= 1'b0;
							state_q    <= ST_I_RD;
						end else if (in_mode == MODE_READ && idx_ok) begin
							i_q        <= CW'(in_idx);
							cnt_mode_q <= 1'b1;
							state_q    <= ST_I_RD;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_I_RD:  state_q <= ST_I_LAT;
				ST_I_LAT: state_q <= ST_RSQ;
				ST_RSQ:   state_q <= ST_RSQ2;
				ST_RSQ2: begin
					j_q     <= '0;
					state_q <= ST_J_RD;
				end
				ST_J_RD: begin
					if (j_q == END_IDX) begin
						state_q <= cnt_mode_q ? ST_OUT : ST_I_WB;
					end else if (j_q[AW-1:0] == i_q[AW-1:0]) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= ST_J_DX;
					end
				end
				ST_J_DX: state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_D2;
				ST_D2:   state_q <= ST_CHK;
				ST_CHK: begin
					axis_q <= 1'b0;
					if (!cnt_mode_q && d2_q != '0 && d2_q < 34'(r2_q)) begin
						state_q <= ST_F;
					end else begin
						state_q <= ST_J_NEXT;
					end
				end
				ST_F: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (sq_bit_q[0]) begin
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_SUM;
				ST_SUM: begin
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'(DIV_BITS - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_MUL_LO;
					end else begin
						state_q <= ST_J_NEXT;
					end
				end
				ST_J_NEXT: begin
					j_q     <= j_q + 1'b1;
					state_q <= ST_J_RD;
				end
				ST_I_WB: begin
					if (i_q == LAST_IDX) begin
						i_q     <= '0;
						state_q <= ST_G_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_I_RD;
					end
				end
				ST_G_RD:  state_q <= ST_G_LAT;
				ST_G_LAT: state_q <= ST_G_MX;
				ST_G_MX:  state_q <= ST_G_MY;
				ST_G_MY:  state_q <= ST_G_PY;
				ST_G_PY:  state_q <= ST_G_RX;
				ST_G_RX:  state_q <= ST_G_RY;
				ST_G_RY: begin
					if (i_q == LAST_IDX) begin
						i_q     <= '0;
						state_q <= ST_OUT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_G_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				m_tdata_q <= '0;
			end
			ST_I_LAT, ST_G_LAT: begin
				xi_q  <= rd_px_q;
				yi_q  <= rd_py_q;
				vxi_q <= rd_vx_q;
				vyi_q <= (state_q == ST_I_LAT && !cnt_mode_q && cfg_grav_en_q) ?
					grav_vy : rd_vy_q;
			end
			ST_RSQ2: begin
				r2_q    <= prod_q[29:0];
				acc_x_q <= '0;
				acc_y_q <= '0;
				count_q <= '0;
			end
			ST_J_RD: begin
				if (j_q == END_IDX && cnt_mode_q) begin
					m_tdata_q <= {2'd0, count_q, vyi_q, vxi_q, yi_q, xi_q};
				end
			end
			ST_J_DX: begin
				dx_q <= 17'(rd_px_q) - 17'(xi_q);
				dy_q <= 17'(rd_py_q) - 17'(yi_q);
			end
			ST_SQY: begin
				d2_q <= 34'(prod_q[32:0]);
			end
			ST_D2: begin
				d2_q <= d2_q + 34'(prod_q[32:0]);
			end
			ST_CHK: begin
				// neighbour count, coincident particles included
				if (cnt_mode_q && d2_q < 34'(r2_q) && count_q != 6'h3F) begin
					count_q <= count_q + 1'b1;
				end
				sq_v_q   <= d2_q[29:0];
				sq_res_q <= '0;
				sq_bit_q <= 30'(1) << 28;
			end
			ST_F: begin
				f_q <= prod_q;
			end
			ST_SQRT: begin
				if (sq_take) begin
					sq_v_q   <= sq_v_q - sq_try;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_MUL_HI: begin
				a_lo_q <= prod_q[38:0];
			end
			ST_SUM: begin
				dnum_q <= a_sum[60:24];
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q  <= div_take ? 15'(rem_sh - {1'b0, sq_root}) : rem_sh[14:0];
				dnum_q <= {dnum_q[35:0], div_take};
			end
			ST_ACC: begin
				// sign of the term follows the gain and the axis offset
				if (axis_q) begin
					acc_y_q <= (cfg_gain_q[15] ^ d_axis[16]) ?
						acc_y_q - 40'(dnum_q) : acc_y_q + 40'(dnum_q);
				end else begin
					acc_x_q <= (cfg_gain_q[15] ^ d_axis[16]) ?
						acc_x_q - 40'(dnum_q) : acc_x_q + 40'(dnum_q);
				end
			end
			ST_G_MY: begin
				nx_q  <= ip_new;
				clx_q <= ip_lo || ip_hi;
			end
			ST_G_PY: begin
				ny_q  <= ip_new;
				cly_q <= ip_lo || ip_hi;
			end
			ST_G_RX: begin
				nvx_q <= clx_q ? rf_vel : vxi_q;
			end
			ST_G_RY: begin
				m_tdata_q <= '0;
			end
			default: ;
		endcase
	end

endmodule
